FILE: hdl/tts_pkg.sv
// Shared types, constants and character classification for the token scanner.
package tts_pkg;

  localparam int NUMBER_MAX_DEF = 32;
  localparam int FRONT_DEPTH    = 2;
  localparam int RESULT_DEPTH   = 4;

  // Token kinds
  localparam logic [3:0] K_KEYWORD = 4'd0;
  localparam logic [3:0] K_END     = 4'd1;
  localparam logic [3:0] K_INT     = 4'd2;
  localparam logic [3:0] K_REAL    = 4'd3;
  localparam logic [3:0] K_STRING  = 4'd4;
  localparam logic [3:0] K_OP      = 4'd5;
  localparam logic [3:0] K_OP2     = 4'd6;
  localparam logic [3:0] K_EXIT    = 4'd7;
  localparam logic [3:0] K_ERROR   = 4'd8;
  localparam logic [3:0] K_NONE    = 4'd0;

  // Configuration register indexes
  localparam logic [2:0] R_NO_SPACE_JOINING = 3'd0;
  localparam logic [2:0] R_SEPARATOR_A      = 3'd1;
  localparam logic [2:0] R_SEPARATOR_B      = 3'd2;
  localparam logic [2:0] R_SEPARATOR_C      = 3'd3;
  localparam logic [2:0] R_SEPARATOR_D      = 3'd4;

  localparam logic [3:0] FORM_START = 4'd0;
  localparam logic [3:0] FORM_DEAD  = 4'd15;

  // End-word matcher progress
  localparam logic [1:0] EW_NONE = 2'd0;
  localparam logic [1:0] EW_E    = 2'd1;
  localparam logic [1:0] EW_EN   = 2'd2;
  localparam logic [1:0] EW_END  = 2'd3;

  typedef enum logic [3:0] {
    M_IDLE, M_WORD_FIRST, M_WORD, M_SLASH, M_LINE, M_BLOCK,
    M_STAR, M_PAIR, M_NUMBER, M_STRING, M_ESCAPE
  } scan_mode_t;

  typedef enum logic [2:0] {
    E_IDLE, E_FETCH, E_EXEC, E_NRD, E_NOUT, E_FLUSH, E_DONE
  } eng_state_t;

  typedef struct packed {
    logic       no_space_joining;
    logic [7:0] separator_a;
    logic [7:0] separator_b;
    logic [7:0] separator_c;
    logic [7:0] separator_d;
  } cfg_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } item_t;

  typedef struct packed {
    logic [7:0]  token_byte;
    logic [3:0]  token_kind;
    logic        token_first;
    logic        token_last;
    logic [15:0] token_line;
    logic        run_last;
  } res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_word_start(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return is_word_start(c) || is_digit(c);
  endfunction

  function automatic logic is_xdigit(input logic [7:0] c);
    return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic is_sep(input logic [7:0] c, input cfg_t cfg);
    return (c == cfg.separator_a) || (c == cfg.separator_b) ||
           (c == cfg.separator_c) || (c == cfg.separator_d);
  endfunction

  function automatic logic is_ws(input logic [7:0] c, input cfg_t cfg);
    return (c == " ") || (c == "\t") || (c == "\n") || (c == 8'd11) ||
           (c == 8'd12) || (c == "\r") || is_sep(c, cfg);
  endfunction

  function automatic logic is_blank(input logic [7:0] c, input cfg_t cfg);
    return ((c == " ") || (c == "\t")) && !is_sep(c, cfg);
  endfunction

  // Real form recognizer: digits . [digits] or . digits, then optional e [+-] digits; or digits e [+-] digits
  function automatic logic [3:0] real_step(input logic [3:0] s, input logic [7:0] c);
    logic [3:0] n;
    n = FORM_DEAD;
    unique case (s)
      4'd0: n = is_digit(c) ? 4'd1 : ((c == ".") ? 4'd2 : FORM_DEAD);
      4'd1: n = is_digit(c) ? 4'd1 : ((c == ".") ? 4'd3 :
                (((c == "e") || (c == "E")) ? 4'd4 : FORM_DEAD));
      4'd2: n = is_digit(c) ? 4'd3 : FORM_DEAD;
      4'd3: n = is_digit(c) ? 4'd3 : (((c == "e") || (c == "E")) ? 4'd4 : FORM_DEAD);
      4'd4: n = ((c == "+") || (c == "-")) ? 4'd5 : (is_digit(c) ? 4'd6 : FORM_DEAD);
      4'd5, 4'd6: n = is_digit(c) ? 4'd6 : FORM_DEAD;
      default: n = FORM_DEAD;
    endcase
    return n;
  endfunction

  // Integer form recognizer: decimal, 0x hex, leading-zero octal
  function automatic logic [3:0] int_step(input logic [3:0] s, input logic [7:0] c);
    logic       oct;
    logic [3:0] n;
    oct = (c >= "0") && (c <= "7");
    n   = FORM_DEAD;
    unique case (s)
      4'd0: n = (c == "0") ? 4'd2 : (is_digit(c) ? 4'd1 : FORM_DEAD);
      4'd1: n = is_digit(c) ? 4'd1 : FORM_DEAD;
      4'd2: n = oct ? 4'd4 : (((c == "x") || (c == "X")) ? 4'd3 : FORM_DEAD);
      4'd3, 4'd5: n = is_xdigit(c) ? 4'd5 : FORM_DEAD;
      4'd4: n = oct ? 4'd4 : FORM_DEAD;
      default: n = FORM_DEAD;
    endcase
    return n;
  endfunction

  function automatic logic real_ok(input logic [3:0] s);
    return (s == 4'd3) || (s == 4'd6);
  endfunction

  function automatic logic int_ok(input logic [3:0] s);
    return (s == 4'd1) || (s == 4'd2) || (s == 4'd4) || (s == 4'd5);
  endfunction

  function automatic logic [15:0] line_inc(input logic [15:0] l);
    return (l == 16'hFFFF) ? l : l + 16'd1;
  endfunction

endpackage

FILE: hdl/tts_ram.sv
// Generic single-port-write, registered-read RAM.
module tts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/tts_fifo.sv
// Small register FIFO used for the item queue and the result queue.
module tts_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] buf_r [DEPTH];
  logic [AW-1:0]    head_r, head_nxt;
  logic [AW-1:0]    tail_r, tail_nxt;
  logic [CW-1:0]    cnt_r,  cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = buf_r[head_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointer and count update
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      tail_nxt = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
    end
    if (do_pop) begin
      head_nxt = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_r[tail_r] <= wdata;
    end
  end

endmodule

FILE: hdl/tts_engine.sv
// Scanning engine: replays buffered characters, builds tokens, emits result beats.
module tts_engine #(
  parameter int NUMBER_MAX = tts_pkg::NUMBER_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  tts_pkg::cfg_t cfg,
  input  logic          item_empty,
  input  tts_pkg::item_t item,
  output logic          item_pop,
  input  logic          res_full,
  output logic          res_push,
  output tts_pkg::res_t res_data
);
  import tts_pkg::*;

  localparam int AW = $clog2(NUMBER_MAX + 2);
  localparam int DEPTH = 1 << AW;

  eng_state_t  st_r, st_nxt;
  scan_mode_t  mode_r, mode_nxt;
  logic        flush_r, flush_nxt;
  logic        sub_r, sub_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        sp_r, sp_nxt;
  logic [1:0]  ewm_r, ewm_nxt;
  logic [15:0] line_r, line_nxt;
  logic [15:0] tsl_r, tsl_nxt;
  logic [3:0]  rf_r, rf_nxt;
  logic [3:0]  ri_r, ri_nxt;
  logic [AW-1:0] fb_r, fb_nxt;
  logic [AW-1:0] ib_r, ib_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] nbs_r, nbs_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] used_r, used_nxt;
  logic [3:0]  nkind_r, nkind_nxt;
  res_t        pend_r, pend_nxt;
  logic        pend_v_r, pend_v_nxt;

  logic          we;
  logic [AW-1:0] raddr;
  logic [7:0]    c;
  logic          emit_req;
  res_t          emit_res;
  logic          stall;
  logic [3:0]    nf, ni;
  logic [AW-1:0] len;
  logic          two;
  logic          nlast;

  function automatic res_t mk(input logic [7:0] b, input logic [3:0] k, input logic f,
                              input logic l, input logic [15:0] ln);
    res_t r;
    r.token_byte  = b;
    r.token_kind  = k;
    r.token_first = f;
    r.token_last  = l;
    r.token_line  = ln;
    r.run_last    = 1'b0;
    return r;
  endfunction

  // Circular character buffer: number text followed by characters to rescan
  tts_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_buf (
    .clk   (clk),
    .we    (we),
    .waddr (wp_r),
    .wdata (item.text_byte),
    .raddr (raddr),
    .rdata (c)
  );

  assign raddr = ((st_r == E_NRD) || (st_r == E_NOUT)) ? nbs_r + idx_r : rp_r;
  assign nf    = real_step(rf_r, c);
  assign ni    = int_step(ri_r, c);
  assign len   = rp_r - nbs_r;
  assign two   = (((held_r == "<") || (held_r == ">")) && (c == "=")) ||
                 ((held_r == "&") && (c == "&")) || ((held_r == "|") && (c == "|"));
  assign nlast = (idx_r + 1'b1 == used_r);
  assign stall = emit_req && pend_v_r && res_full;

  // Next state, scanning actions and result emission
  always_comb begin
    st_nxt     = st_r;
    mode_nxt   = mode_r;
    flush_nxt  = flush_r;
    sub_nxt    = sub_r;
    held_nxt   = held_r;
    sp_nxt     = sp_r;
    ewm_nxt    = ewm_r;
    line_nxt   = line_r;
    tsl_nxt    = tsl_r;
    rf_nxt     = rf_r;
    ri_nxt     = ri_r;
    fb_nxt     = fb_r;
    ib_nxt     = ib_r;
    rp_nxt     = rp_r;
    wp_nxt     = wp_r;
    nbs_nxt    = nbs_r;
    idx_nxt    = idx_r;
    used_nxt   = used_r;
    nkind_nxt  = nkind_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    we         = 1'b0;
    item_pop   = 1'b0;
    res_push   = 1'b0;
    res_data   = pend_r;
    emit_req   = 1'b0;
    emit_res   = pend_r;

    unique case (st_r)
      E_IDLE: begin
        if (!item_empty) begin
          item_pop = 1'b1;
          if (item.end_of_text) begin
            flush_nxt = 1'b1;
            st_nxt    = E_FLUSH;
          end else begin
            we     = 1'b1;
            wp_nxt = wp_r + 1'b1;
            st_nxt = E_FETCH;
          end
        end
      end

      E_FETCH: begin
        if (rp_r == wp_r) begin
          st_nxt = flush_r ? E_FLUSH : E_DONE;
        end else begin
          st_nxt = E_EXEC;
        end
      end

      E_EXEC: begin
        unique case (mode_r)
          M_IDLE: begin
            tsl_nxt = line_r;
            rp_nxt  = rp_r + 1'b1;
            st_nxt  = E_FETCH;
            if (c == 8'd0) begin
              emit_req = 1'b1;
              emit_res = mk(8'd0, K_ERROR, 1'b1, 1'b1, line_r);
            end else if (is_ws(c, cfg)) begin
              if (c == "\n") line_nxt = line_inc(line_r);
            end else if (c == "/") begin
              held_nxt = c;
              mode_nxt = M_SLASH;
            end else if (is_word_start(c)) begin
              held_nxt = c;
              sp_nxt   = 1'b0;
              ewm_nxt  = (c == "e") ? EW_E : EW_NONE;
              mode_nxt = M_WORD_FIRST;
            end else if (is_digit(c) || (c == ".")) begin
              nbs_nxt  = rp_r;
              rf_nxt   = real_step(FORM_START, c);
              ri_nxt   = int_step(FORM_START, c);
              fb_nxt   = real_ok(real_step(FORM_START, c)) ? AW'(1) : '0;
              ib_nxt   = int_ok(int_step(FORM_START, c)) ? AW'(1) : '0;
              mode_nxt = M_NUMBER;
            end else if (c == "\"") begin
              emit_req = 1'b1;
              emit_res = mk(c, K_NONE, 1'b1, 1'b0, line_r);
              mode_nxt = M_STRING;
            end else if (c == "#") begin
              emit_req = 1'b1;
              emit_res = mk(c, K_ERROR, 1'b1, 1'b1, line_r);
            end else if ((c == "<") || (c == ">") || (c == "&") || (c == "|")) begin
              held_nxt = c;
              mode_nxt = M_PAIR;
            end else begin
              emit_req = 1'b1;
              emit_res = mk(c, K_OP, 1'b1, 1'b1, line_r);
            end
          end

          M_WORD_FIRST, M_WORD: begin
            if (sub_r) begin
              // joining space between two words
              emit_req = 1'b1;
              emit_res = mk(" ", K_NONE, 1'b0, 1'b0, tsl_r);
              sp_nxt   = 1'b0;
              ewm_nxt  = EW_NONE;
              held_nxt = c;
              mode_nxt = M_WORD;
              sub_nxt  = 1'b0;
              rp_nxt   = rp_r + 1'b1;
              st_nxt   = E_FETCH;
            end else if (is_word_char(c) && !(sp_r && is_digit(c))) begin
              emit_req = 1'b1;
              emit_res = mk(held_r, K_NONE, mode_r == M_WORD_FIRST, 1'b0, tsl_r);
              if (sp_r) begin
                sub_nxt  = 1'b1;
                mode_nxt = M_WORD;
              end else begin
                if ((ewm_r == EW_E) && (c == "n")) ewm_nxt = EW_EN;
                else if ((ewm_r == EW_EN) && (c == "d")) ewm_nxt = EW_END;
                else ewm_nxt = EW_NONE;
                held_nxt = c;
                mode_nxt = M_WORD;
                rp_nxt   = rp_r + 1'b1;
                st_nxt   = E_FETCH;
              end
            end else if (!cfg.no_space_joining && is_blank(c, cfg)) begin
              sp_nxt = 1'b1;
              rp_nxt = rp_r + 1'b1;
              st_nxt = E_FETCH;
            end else begin
              emit_req = 1'b1;
              emit_res = mk(held_r, (ewm_r == EW_END) ? K_END : K_KEYWORD,
                            mode_r == M_WORD_FIRST, 1'b1, tsl_r);
              sp_nxt   = 1'b0;
              ewm_nxt  = EW_NONE;
              mode_nxt = M_IDLE;
            end
          end

          M_SLASH: begin
            if (c == "/") begin
              mode_nxt = M_LINE;
              rp_nxt   = rp_r + 1'b1;
              st_nxt   = E_FETCH;
            end else if (c == "*") begin
              mode_nxt = M_BLOCK;
              rp_nxt   = rp_r + 1'b1;
              st_nxt   = E_FETCH;
            end else begin
              emit_req = 1'b1;
              emit_res = mk("/", K_OP, 1'b1, 1'b1, tsl_r);
              mode_nxt = M_IDLE;
            end
          end

          M_LINE: begin
            if (c == "\n") begin
              line_nxt = line_inc(line_r);
              mode_nxt = M_IDLE;
            end
            rp_nxt = rp_r + 1'b1;
            st_nxt = E_FETCH;
          end

          M_BLOCK: begin
            if (c == "*") mode_nxt = M_STAR;
            else if (c == "\n") line_nxt = line_inc(line_r);
            rp_nxt = rp_r + 1'b1;
            st_nxt = E_FETCH;
          end

          M_STAR: begin
            if (c == "/") begin
              mode_nxt = M_IDLE;
            end else if (c != "*") begin
              if (c == "\n") line_nxt = line_inc(line_r);
              mode_nxt = M_BLOCK;
            end
            rp_nxt = rp_r + 1'b1;
            st_nxt = E_FETCH;
          end

          M_PAIR: begin
            emit_req = 1'b1;
            if (sub_r) begin
              emit_res = mk(c, K_OP2, 1'b0, 1'b1, tsl_r);
              sub_nxt  = 1'b0;
              mode_nxt = M_IDLE;
              rp_nxt   = rp_r + 1'b1;
              st_nxt   = E_FETCH;
            end else if (two) begin
              emit_res = mk(held_r, K_NONE, 1'b1, 1'b0, tsl_r);
              sub_nxt  = 1'b1;
            end else begin
              emit_res = mk(held_r, K_OP, 1'b1, 1'b1, tsl_r);
              mode_nxt = M_IDLE;
            end
          end

          M_NUMBER: begin
            if ((nf == FORM_DEAD) && (ni == FORM_DEAD)) begin
              // longest form wins, tie to integer; rest is rescanned
              idx_nxt = '0;
              st_nxt  = E_NRD;
              if (fb_r > ib_r) begin
                used_nxt  = fb_r;
                nkind_nxt = K_REAL;
              end else if (ib_r != '0) begin
                used_nxt  = ib_r;
                nkind_nxt = K_INT;
              end else begin
                used_nxt  = AW'(1);
                nkind_nxt = K_OP;
              end
            end else if (len >= AW'(NUMBER_MAX)) begin
              emit_req = 1'b1;
              emit_res = mk(8'd0, K_ERROR, 1'b1, 1'b1, tsl_r);
              rf_nxt   = FORM_START;
              ri_nxt   = FORM_START;
              fb_nxt   = '0;
              ib_nxt   = '0;
              mode_nxt = M_IDLE;
            end else begin
              rf_nxt = nf;
              ri_nxt = ni;
              if (real_ok(nf)) fb_nxt = len + 1'b1;
              if (int_ok(ni)) ib_nxt = len + 1'b1;
              rp_nxt = rp_r + 1'b1;
              st_nxt = E_FETCH;
            end
          end

          M_STRING: begin
            emit_req = 1'b1;
            rp_nxt   = rp_r + 1'b1;
            st_nxt   = E_FETCH;
            if (c == "\"") begin
              emit_res = mk(c, K_STRING, 1'b0, 1'b1, tsl_r);
              mode_nxt = M_IDLE;
            end else if (c == "\\") begin
              emit_res = mk(c, K_NONE, 1'b0, 1'b0, tsl_r);
              mode_nxt = M_ESCAPE;
            end else if ((c == "\n") || (c == 8'd0)) begin
              emit_res = mk(c, K_ERROR, 1'b0, 1'b1, tsl_r);
              if (c == "\n") line_nxt = line_inc(line_r);
              mode_nxt = M_IDLE;
            end else begin
              emit_res = mk(c, K_NONE, 1'b0, 1'b0, tsl_r);
            end
          end

          M_ESCAPE: begin
            emit_req = 1'b1;
            emit_res = mk(c, K_NONE, 1'b0, 1'b0, tsl_r);
            if (c == "\n") line_nxt = line_inc(line_r);
            mode_nxt = M_STRING;
            rp_nxt   = rp_r + 1'b1;
            st_nxt   = E_FETCH;
          end

          default: begin
            mode_nxt = M_IDLE;
          end
        endcase
      end

      E_NRD: begin
        st_nxt = E_NOUT;
      end

      // Emit the winning number prefix from the buffer
      E_NOUT: begin
        emit_req = 1'b1;
        emit_res = mk(c, nlast ? nkind_r : K_NONE, idx_r == '0, nlast, tsl_r);
        if (nlast) begin
          rp_nxt   = nbs_r + used_r;
          rf_nxt   = FORM_START;
          ri_nxt   = FORM_START;
          fb_nxt   = '0;
          ib_nxt   = '0;
          mode_nxt = M_IDLE;
          st_nxt   = E_FETCH;
        end else begin
          idx_nxt = idx_r + 1'b1;
          st_nxt  = E_NRD;
        end
      end

      // End of text: resolve numbers, close open token, then exit
      E_FLUSH: begin
        priority case (mode_r)
          M_NUMBER: begin
            idx_nxt = '0;
            st_nxt  = E_NRD;
            if (fb_r > ib_r) begin
              used_nxt  = fb_r;
              nkind_nxt = K_REAL;
            end else if (ib_r != '0) begin
              used_nxt  = ib_r;
              nkind_nxt = K_INT;
            end else begin
              used_nxt  = AW'(1);
              nkind_nxt = K_OP;
            end
          end
          M_WORD_FIRST, M_WORD: begin
            emit_req = 1'b1;
            emit_res = mk(held_r, (ewm_r == EW_END) ? K_END : K_KEYWORD,
                          mode_r == M_WORD_FIRST, 1'b1, tsl_r);
            mode_nxt = M_IDLE;
          end
          M_SLASH: begin
            emit_req = 1'b1;
            emit_res = mk("/", K_OP, 1'b1, 1'b1, tsl_r);
            mode_nxt = M_IDLE;
          end
          M_PAIR: begin
            emit_req = 1'b1;
            emit_res = mk(held_r, K_OP, 1'b1, 1'b1, tsl_r);
            mode_nxt = M_IDLE;
          end
          M_STRING, M_ESCAPE: begin
            emit_req = 1'b1;
            emit_res = mk(8'd0, K_ERROR, 1'b0, 1'b1, tsl_r);
            mode_nxt = M_IDLE;
          end
          default: begin
            emit_req  = 1'b1;
            emit_res  = mk(8'd0, K_EXIT, 1'b1, 1'b1, line_r);
            sp_nxt    = 1'b0;
            ewm_nxt   = EW_NONE;
            mode_nxt  = M_IDLE;
            flush_nxt = 1'b0;
            st_nxt    = E_DONE;
          end
        endcase
      end

      // Release the held beat marked as the last of this item
      E_DONE: begin
        if (pend_v_r) begin
          if (!res_full) begin
            res_push          = 1'b1;
            res_data          = pend_r;
            res_data.run_last = 1'b1;
            pend_v_nxt        = 1'b0;
            st_nxt            = E_IDLE;
          end
        end else begin
          st_nxt = E_IDLE;
        end
      end

      default: begin
        st_nxt = E_IDLE;
      end
    endcase

    // New beat goes to the holding register; the older one moves on
    if (emit_req && !stall) begin
      if (pend_v_r) begin
        res_push = 1'b1;
        res_data = pend_r;
      end
      pend_nxt   = emit_res;
      pend_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= E_IDLE;
      mode_r   <= M_IDLE;
      flush_r  <= 1'b0;
      sub_r    <= 1'b0;
      held_r   <= 8'd0;
      sp_r     <= 1'b0;
      ewm_r    <= EW_NONE;
      line_r   <= 16'd1;
      tsl_r    <= 16'd1;
      rf_r     <= FORM_START;
      ri_r     <= FORM_START;
      fb_r     <= '0;
      ib_r     <= '0;
      rp_r     <= '0;
      wp_r     <= '0;
      nbs_r    <= '0;
      pend_v_r <= 1'b0;
    end else if (!stall) begin
      st_r     <= st_nxt;
      mode_r   <= mode_nxt;
      flush_r  <= flush_nxt;
      sub_r    <= sub_nxt;
      held_r   <= held_nxt;
      sp_r     <= sp_nxt;
      ewm_r    <= ewm_nxt;
      line_r   <= line_nxt;
      tsl_r    <= tsl_nxt;
      rf_r     <= rf_nxt;
      ri_r     <= ri_nxt;
      fb_r     <= fb_nxt;
      ib_r     <= ib_nxt;
      rp_r     <= rp_nxt;
      wp_r     <= wp_nxt;
      nbs_r    <= nbs_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (!stall) begin
      idx_r   <= idx_nxt;
      used_r  <= used_nxt;
      nkind_r <= nkind_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

FILE: hdl/text_token_scanner_core.sv
// Top level of the C-style token scanner: config registers, item queue, engine, result queue.
//
// Text bytes enter through a short item queue and are written into a circular character
// buffer; the scanning engine reads them back one at a time (a fetch step, then a decode
// step) and emits result beats into the result queue, taking the next byte from the item
// queue only once it has finished with the previous one. A plain byte passes through
// dequeue, fetch, decode, an empty fetch and release of the last beat, with a further
// decode step for each extra beat it produces without consuming a character. A number is
// held in the buffer until no form can grow; each character of its winning prefix is then
// read and emitted, and the leftover characters are decoded again. An end marker is
// dequeued, open tokens are closed, and an exit beat is emitted and released. The engine
// stalls while it has a new beat, one beat is held back and the result queue is full.
module text_token_scanner_core #(
  parameter int NUMBER_MAX = tts_pkg::NUMBER_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // item channel
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_text,
  // result channel
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_token_byte,
  output logic [3:0]  out_token_kind,
  output logic        out_token_first,
  output logic        out_token_last,
  output logic [15:0] out_token_line,
  output logic        out_run_last,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import tts_pkg::*;

  cfg_t  cfg_r;
  item_t in_item, eng_item;
  logic  item_empty, item_pop;
  logic  res_full, res_push;
  res_t  res_in, res_out;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.no_space_joining <= 1'b0;
      cfg_r.separator_a      <= "=";
      cfg_r.separator_b      <= ":";
      cfg_r.separator_c      <= ";";
      cfg_r.separator_d      <= ",";
    end else if (cfg_we) begin
      unique case (cfg_index)
        R_NO_SPACE_JOINING: cfg_r.no_space_joining <= cfg_data[0];
        R_SEPARATOR_A:      cfg_r.separator_a      <= cfg_data;
        R_SEPARATOR_B:      cfg_r.separator_b      <= cfg_data;
        R_SEPARATOR_C:      cfg_r.separator_c      <= cfg_data;
        R_SEPARATOR_D:      cfg_r.separator_d      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_item.text_byte   = in_text_byte;
  assign in_item.end_of_text = in_end_of_text;

  // Front: item queue
  tts_fifo #(.WIDTH($bits(item_t)), .DEPTH(FRONT_DEPTH)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (in_item),
    .full  (full),
    .pop   (item_pop),
    .rdata (eng_item),
    .empty (item_empty)
  );

  // Back: scanning engine
  tts_engine #(.NUMBER_MAX(NUMBER_MAX)) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_empty (item_empty),
    .item       (eng_item),
    .item_pop   (item_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_data   (res_in)
  );

  // Result queue
  tts_fifo #(.WIDTH($bits(res_t)), .DEPTH(RESULT_DEPTH)) u_result (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign out_token_byte  = res_out.token_byte;
  assign out_token_kind  = res_out.token_kind;
  assign out_token_first = res_out.token_first;
  assign out_token_last  = res_out.token_last;
  assign out_token_line  = res_out.token_line;
  assign out_run_last    = res_out.run_last;

endmodule
